// File: design/mse_pkg.sv
// shared types and constants for the mips subset execute block
// no dependencies
`default_nettype none

package mse_pkg;

  localparam int unsigned XLEN   = 32;
  localparam int unsigned RIDX_W = 5;
  localparam int unsigned NREGS  = 32;

  // r-type match: opcode, shamt and funct bits
  localparam logic [XLEN-1:0] RTYPE_MASK = 32'hfc0007ff;
  localparam logic [XLEN-1:0] FN_ADD     = 32'h00000020;
  localparam logic [XLEN-1:0] FN_SUB     = 32'h00000022;
  localparam logic [XLEN-1:0] FN_MUL     = 32'h70000002;
  localparam logic [XLEN-1:0] FN_AND     = 32'h00000024;
  localparam logic [XLEN-1:0] FN_OR      = 32'h00000025;
  localparam logic [XLEN-1:0] FN_SLT     = 32'h0000002a;

  localparam logic [5:0] OP_BEQ  = 6'd4;
  localparam logic [5:0] OP_BNE  = 6'd5;
  localparam logic [5:0] OP_ADDI = 6'd8;
  localparam logic [5:0] OP_SLTI = 6'd10;
  localparam logic [5:0] OP_ANDI = 6'd12;
  localparam logic [5:0] OP_ORI  = 6'd13;
  localparam logic [5:0] OP_LUI  = 6'd15;

  localparam logic [XLEN-1:0] PC_STEP = 32'd4;

  typedef struct packed {
    logic [XLEN-1:0]   next_pc;
    logic [RIDX_W-1:0] dest_index;
    logic [XLEN-1:0]   dest_value;
    logic              dest_written;
    logic              recognized;
  } exec_res_t;

  function automatic logic [RIDX_W-1:0] rs_of(input logic [XLEN-1:0] w);
    return w[25:21];
  endfunction

  function automatic logic [RIDX_W-1:0] rt_of(input logic [XLEN-1:0] w);
    return w[20:16];
  endfunction

endpackage

`default_nettype wire

// File: design/mse_alu.sv
// decode and execute of one instruction word against its operands and pc
// depends on mse_pkg
`default_nettype none

module mse_alu import mse_pkg::*; (
  input  wire logic [XLEN-1:0] instr,
  input  wire logic [XLEN-1:0] opnd_a,
  input  wire logic [XLEN-1:0] opnd_b,
  input  wire logic [XLEN-1:0] pc,
  output exec_res_t            res
);

  logic [5:0]        op;
  logic [RIDX_W-1:0] rd;
  logic [RIDX_W-1:0] rt;
  logic [XLEN-1:0]   imm_z;
  logic [XLEN-1:0]   imm_s;
  logic [XLEN-1:0]   rtype;
  logic [XLEN-1:0]   prod;
  logic [XLEN-1:0]   val;
  logic [RIDX_W-1:0] dest;
  logic              writes;
  logic              known;
  logic              taken;
  logic [XLEN-1:0]   pc_seq;
  logic [XLEN-1:0]   pc_br;

  assign op     = instr[31:26];
  assign rd     = instr[15:11];
  assign rt     = rt_of(instr);
  assign imm_z  = {16'h0000, instr[15:0]};
  assign imm_s  = {{16{instr[15]}}, instr[15:0]};
  assign rtype  = instr & RTYPE_MASK;
  assign prod   = opnd_a * opnd_b;
  assign pc_seq = pc + PC_STEP;
  assign pc_br  = pc + {imm_s[XLEN-3:0], 2'b00};

  always_comb begin
    val    = '0;
    dest   = '0;
    writes = 1'b0;
    known  = 1'b1;
    taken  = 1'b0;
    unique case (rtype)
      FN_ADD: begin
        dest = rd; val = opnd_a + opnd_b; writes = 1'b1;
      end
      FN_SUB: begin
        dest = rd; val = opnd_a - opnd_b; writes = 1'b1;
      end
      FN_MUL: begin
        dest = rd; val = prod; writes = 1'b1;
      end
      FN_AND: begin
        dest = rd; val = opnd_a & opnd_b; writes = 1'b1;
      end
      FN_OR: begin
        dest = rd; val = opnd_a | opnd_b; writes = 1'b1;
      end
      FN_SLT: begin
        dest = rd; val = {31'd0, $signed(opnd_a) < $signed(opnd_b)}; writes = 1'b1;
      end
      default: begin
        unique case (op)
          OP_ADDI: begin
            dest = rt; val = opnd_a + imm_s; writes = 1'b1;
          end
          OP_ANDI: begin
            dest = rt; val = opnd_a & imm_z; writes = 1'b1;
          end
          OP_ORI: begin
            dest = rt; val = opnd_a | imm_z; writes = 1'b1;
          end
          OP_SLTI: begin
            dest = rt; val = {31'd0, $signed(opnd_a) < $signed(imm_s)}; writes = 1'b1;
          end
          OP_LUI: begin
            dest = rt; val = {instr[15:0], 16'h0000}; writes = 1'b1;
          end
          OP_BEQ: taken = (opnd_a == opnd_b);
          OP_BNE: taken = (opnd_a != opnd_b);
          default: known = 1'b0;
        endcase
      end
    endcase
  end

  // writes to register zero are dropped and reported as no write
  always_comb begin
    res.next_pc    = taken ? pc_br : pc_seq;
    res.recognized = known;
    if (writes && (dest != '0)) begin
      res.dest_index   = dest;
      res.dest_value   = val;
      res.dest_written = 1'b1;
    end else begin
      res.dest_index   = '0;
      res.dest_value   = '0;
      res.dest_written = 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: design/mips_subset_execute.sv
// top level of the mips subset execute block: register file, pc and stream handshakes
// depends on mse_pkg and mse_alu
`default_nettype none

// mips_subset_execute
// executes one 32-bit mips instruction word per input transaction against a
// 32-entry register file and a program counter, and returns one result
// transaction per instruction.
// input channel: in_tdata carries the instruction word.
// result channel: out_tdata carries next pc, destination index and value,
// out_tuser carries the write and recognised flags.
// pipeline: on acceptance, rs and rt are read from the register file into
// the operand registers of the execute stage (with a bypass from the
// instruction committing in the same cycle); that stage runs the alu and
// loads the output register while writing the register file.
// throughput: one transaction per cycle, back to back, while the output is
// not stalled; the register file has one write port.
// reset: pc returns to zero and every register reads as zero (per-entry
// valid bits are cleared at once, so no clearing pass is needed).
// stall: while out_tready is low with a result held, the execute stage keeps
// its instruction and in_tready drops once that stage is occupied.
module mips_subset_execute import mse_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] instr_word
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // [31:0] next_pc, [36:32] dest_index,
                                       // [68:37] dest_value, [71:69] zero
  output logic [1:0]       out_tuser   // [0] dest_written, [1] recognized
);

  // register file storage and per-entry valid bits
  logic [XLEN-1:0] rf_mem [NREGS];
  logic [NREGS-1:0] rf_vld_r;

  // execute stage
  logic              ex_vld_r;
  logic [XLEN-1:0]   ex_instr_r;
  logic [XLEN-1:0]   rd_a_r, rd_b_r;
  logic              vld_a_r, vld_b_r;
  logic              fwd_a_r, fwd_b_r;
  logic [XLEN-1:0]   fwd_val_r;
  logic [XLEN-1:0]   pc_r;

  // output register
  logic              out_vld_r;
  exec_res_t         out_res_r;

  logic              in_fire;
  logic              out_free;
  logic              ex_commit;
  logic              wr_en;
  logic [RIDX_W-1:0] in_rs, in_rt;
  logic [XLEN-1:0]   opnd_a, opnd_b;
  exec_res_t         ex_res;

  assign out_free  = !out_vld_r || out_tready;
  assign ex_commit = ex_vld_r && out_free;
  assign in_tready = !ex_vld_r || out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign in_rs     = rs_of(in_tdata);
  assign in_rt     = rt_of(in_tdata);

  // register file write when the executing instruction leaves the stage
  assign wr_en = ex_commit && ex_res.dest_written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rf_mem[ex_res.dest_index] <= ex_res.dest_value;
    end
    if (in_fire) begin
      rd_a_r <= rf_mem[in_rs];
      rd_b_r <= rf_mem[in_rt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
    end else if (wr_en) begin
      rf_vld_r[ex_res.dest_index] <= 1'b1;
    end
  end

  // operand capture, bypassing a write that lands on the same edge
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ex_instr_r <= in_tdata;
      vld_a_r    <= rf_vld_r[in_rs];
      vld_b_r    <= rf_vld_r[in_rt];
      fwd_a_r    <= wr_en && (ex_res.dest_index == in_rs);
      fwd_b_r    <= wr_en && (ex_res.dest_index == in_rt);
      fwd_val_r  <= ex_res.dest_value;
    end
  end

  // register zero never gets a valid bit, so it reads as zero
  assign opnd_a = fwd_a_r ? fwd_val_r : (vld_a_r ? rd_a_r : '0);
  assign opnd_b = fwd_b_r ? fwd_val_r : (vld_b_r ? rd_b_r : '0);

  mse_alu u_alu (
    .instr  (ex_instr_r),
    .opnd_a (opnd_a),
    .opnd_b (opnd_b),
    .pc     (pc_r),
    .res    (ex_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_vld_r  <= 1'b0;
      pc_r      <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) begin
        ex_vld_r <= in_fire;
      end
      if (ex_commit) begin
        pc_r <= ex_res.next_pc;
      end
      if (out_free) begin
        out_vld_r <= ex_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ex_commit) begin
      out_res_r <= ex_res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, out_res_r.dest_value, out_res_r.dest_index,
                       out_res_r.next_pc};
  assign out_tuser  = {out_res_r.recognized, out_res_r.dest_written};

endmodule

`default_nettype wire
